@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the color map RTL.
// Depends on nothing; the using module supplies clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ rtl/core/tpscm_pkg.sv @@
// Shared types, constants and functions of the thin-plate spline color map.
// Depends on nothing; the cell, kernel and top-level modules import it.
package tpscm_pkg;

	localparam int NUM_CENTERS_DEF = 24;
	localparam int COEF_FRAC_DEF   = 24;
	localparam int LN_TABLE_DEF    = 8;
	localparam int TABLE_CENTERS   = 24;
	localparam int XW              = 16;
	localparam int CW              = 40;
	localparam int DW              = 33;
	localparam int EW              = 6;
	localparam int ACC_W           = 62;
	localparam int LOG_FRAC        = 24;
	localparam logic [19:0] HALF_LN2_Q20 = 20'd363409;
	localparam logic signed [63:0] ACC_LIMIT = 64'sd1 <<< 60;

	typedef logic signed [XW-1:0] pix_t;
	typedef logic signed [CW-1:0] coef_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	// One ring cell: a center color and its three channel weights.
	typedef struct packed {
		logic [2:0][XW-1:0] ctr;
		logic [2:0][CW-1:0] w;
	} tpscm_cell_t;

	// Control travelling with a center through the kernel pipeline.
	typedef struct packed {
		logic               vld;
		logic               last;
		logic [2:0][CW-1:0] w;
	} tpscm_tag_t;

	localparam logic signed [XW-1:0] CENTER_TAB [TABLE_CENTERS*3] = '{
		16'sd2508, 16'sd881, 16'sd915,     16'sd4172, 16'sd1216, 16'sd1108,
		16'sd3165, -16'sd271, -16'sd1469,  16'sd2742, -16'sd853, 16'sd1416,
		16'sd3532, 16'sd604, -16'sd1596,   16'sd4503, -16'sd2097, -16'sd3,
		16'sd4027, 16'sd2271, 16'sd3654,   16'sd2608, 16'sd730, -16'sd2946,
		16'sd3334, 16'sd3079, 16'sd1081,   16'sd1963, 16'sd1356, -16'sd1332,
		16'sd4677, -16'sd1507, 16'sd3646,  16'sd4636, 16'sd1119, 16'sd4365,
		16'sd1982, 16'sd811, -16'sd2963,   16'sd3612, -16'sd2602, 16'sd2044,
		16'sd2778, 16'sd3244, 16'sd1846,   16'sd5277, 16'sd154, 16'sd5136,
		16'sd3327, 16'sd3244, -16'sd950,   16'sd3265, -16'sd1768, -16'sd1794,
		16'sd6142, -16'sd26, 16'sd79,      16'sd5190, -16'sd53, -16'sd28,
		16'sd4276, -16'sd69, -16'sd45,     16'sd3263, -16'sd12, -16'sd19,
		16'sd2286, -16'sd44, -16'sd71,     16'sd1373, 16'sd4, -16'sd61
	};

	// Fractional log2 of 1 + idx / 2^tb by repeated squaring; used only at elaboration.
	function automatic logic [LOG_FRAC-1:0] log2_frac(input int unsigned idx,
			input int unsigned tb);
		logic [63:0]         x;
		logic [LOG_FRAC-1:0] r;
		x = (64'd1 << 30) + (64'(idx) << (30 - tb));
		r = '0;
		for (int b = 1; b <= LOG_FRAC; b++) begin
			x = (x * x) >> 30;
			if (x >= (64'd1 << 31)) begin
				r[LOG_FRAC-b] = 1'b1;
				x = x >> 1;
			end
		end
		return r;
	endfunction

	// Clamps a sum to the accumulator limits of plus or minus 2^60.
	function automatic acc_t clamp_acc(input logic signed [63:0] v);
		if (v > ACC_LIMIT) begin
			return ACC_W'(ACC_LIMIT);
		end else if (v < -ACC_LIMIT) begin
			return ACC_W'(-ACC_LIMIT);
		end
		return ACC_W'(v);
	endfunction

endpackage

@@ rtl/core/tpscm_cell.sv @@
// One cell of the rotating center ring: center color plus its three weights.
// Depends on tpscm_pkg.
module tpscm_cell #(
	parameter int IDX = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     shift,
	input  tpscm_pkg::tpscm_cell_t   nxt,
	input  logic [2:0]               wr_en,
	input  tpscm_pkg::coef_t         wr_val,
	output tpscm_pkg::tpscm_cell_t   data
);
	import tpscm_pkg::*;

	tpscm_cell_t data_q;

	// The ring rotates one cell per cycle during a pixel; weights load only when at rest.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 3; j++) begin
				data_q.ctr[j] <= CENTER_TAB[(IDX % TABLE_CENTERS) * 3 + j];
				data_q.w[j]   <= '0;
			end
		end else if (shift) begin
			data_q <= nxt;
		end else begin
			for (int j = 0; j < 3; j++) begin
				if (wr_en[j]) begin
					data_q.w[j] <= wr_val;
				end
			end
		end
	end

	assign data = data_q;

endmodule

@@ rtl/core/tpscm_kernel.sv @@
// Nine-stage pipeline from pixel and center to the spline kernel value phi.
// Depends on tpscm_pkg.
module tpscm_kernel #(
	parameter int LN_TABLE_BITS = tpscm_pkg::LN_TABLE_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [2:0][tpscm_pkg::XW-1:0]      x,
	input  logic [2:0][tpscm_pkg::XW-1:0]      ctr,
	input  tpscm_pkg::tpscm_tag_t              tag_in,
	output logic signed [tpscm_pkg::CW-1:0]    phi,
	output tpscm_pkg::tpscm_tag_t              tag_out
);
	import tpscm_pkg::*;

	localparam int TN = 1 << LN_TABLE_BITS;

	logic [LOG_FRAC-1:0] log_tab [TN];

	for (genvar gi = 0; gi < TN; gi++) begin : g_tab
		assign log_tab[gi] = log2_frac(gi, LN_TABLE_BITS);
	end

	logic signed [XW:0]           df [3];
	logic signed [XW:0]           df_s1 [3];
	logic [31:0]                  sq_s2 [3];
	logic [DW-1:0]                d_s3, d_s4, d_s5, d_s6, d_s7;
	logic [EW-1:0]                e_lead, e_s4, e_s5;
	logic [DW+LN_TABLE_BITS-1:0]  norm;
	logic [LN_TABLE_BITS-1:0]     idx_s5;
	logic signed [31:0]           lexp, l_s6, k_s7;
	logic signed [52:0]           kmul;
	logic signed [49:0]           ph_s8;
	logic signed [48:0]           pl_s8;
	logic signed [63:0]           prod;
	logic signed [CW-1:0]         phi_s9;
	tpscm_tag_t                   tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	tpscm_tag_t                   tag_s6, tag_s7, tag_s8, tag_s9;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			df[j] = $signed({x[j][XW-1], x[j]}) - $signed({ctr[j][XW-1], ctr[j]});
		end
		e_lead = '0;
		for (int i = 0; i < DW; i++) begin
			if (d_s3[i]) begin
				e_lead = EW'(i);
			end
		end
		norm = {d_s4, {LN_TABLE_BITS{1'b0}}} >> e_s4;
		lexp = $signed({{(32-EW){1'b0}}, e_s5}) - 32'sd12;
		kmul = l_s6 * $signed({1'b0, HALF_LN2_Q20});
		prod = ($signed(64'(ph_s8)) <<< 16) + $signed(64'(pl_s8));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
			tag_s6 <= '0;
			tag_s7 <= '0;
			tag_s8 <= '0;
			tag_s9 <= '0;
		end else begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
			tag_s6 <= tag_s5;
			tag_s7 <= tag_s6;
			tag_s8 <= tag_s7;
			tag_s9 <= tag_s8;
		end
	end

	always_ff @(posedge clk) begin
		df_s1 <= df;
		for (int j = 0; j < 3; j++) begin
			sq_s2[j] <= 32'(df_s1[j] * df_s1[j]);
		end
		d_s3   <= DW'(sq_s2[0]) + DW'(sq_s2[1]) + DW'(sq_s2[2]);
		e_s4   <= e_lead;
		d_s4   <= d_s3;
		idx_s5 <= norm[LN_TABLE_BITS-1:0];
		e_s5   <= e_s4;
		d_s5   <= d_s4;
		l_s6   <= (lexp <<< LOG_FRAC) + $signed({{(32-LOG_FRAC){1'b0}}, log_tab[idx_s5]});
		d_s6   <= d_s5;
		k_s7   <= kmul[51:20];
		d_s7   <= d_s6;
		ph_s8  <= $signed({1'b0, d_s7[DW-1:16]}) * k_s7;
		pl_s8  <= $signed({1'b0, d_s7[15:0]}) * k_s7;
		phi_s9 <= prod[63:24];
	end

	assign phi     = phi_s9;
	assign tag_out = tag_s9;

endmodule

@@ rtl/core/thin_plate_spline_color_map.sv @@
// Thin-plate spline color map: a Lab pixel beat is mapped through a 3D thin-plate
// spline over NUM_CENTERS fixed reference colors, and a coefficient beat (action high)
// stores one of the 3 x (NUM_CENTERS+4) spline coefficients, all cleared at reset.
// The block works on one pixel at a time; after a pixel is accepted, no beat is
// accepted until its result has moved to the output register. The centers and their
// weights sit in a ring of cells that rotates one cell per cycle past a shared kernel
// pipeline: the ring runs NUM_CENTERS steps, the pipeline drains, and the result
// waits until the output register is free. A coefficient beat returns no result and
// leaves the block ready for the next beat. A finished pixel waits in the output
// register; the next beat can be accepted meanwhile.
// Depends on tpscm_pkg, tpscm_cell, tpscm_kernel and assert_macros.svh.
`include "assert_macros.svh"

module thin_plate_spline_color_map #(
	parameter int NUM_CENTERS    = tpscm_pkg::NUM_CENTERS_DEF,
	parameter int COEF_FRAC_BITS = tpscm_pkg::COEF_FRAC_DEF,
	parameter int LN_TABLE_BITS  = tpscm_pkg::LN_TABLE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  tpscm_pkg::pix_t    in_light,
	input  tpscm_pkg::pix_t    in_green_red,
	input  tpscm_pkg::pix_t    in_blue_yellow,
	input  logic [1:0]         coef_channel,
	input  logic [4:0]         coef_slot,
	input  tpscm_pkg::coef_t   coef_value,
	output logic               out_valid,
	input  logic               out_ready,
	output tpscm_pkg::pix_t    out_light,
	output tpscm_pkg::pix_t    out_green_red,
	output tpscm_pkg::pix_t    out_blue_yellow
);
	import tpscm_pkg::*;

	localparam int SW = $clog2(NUM_CENTERS + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_FIN} state_t;

	state_t                 state_q;
	logic [SW-1:0]          step_q;
	logic                   lin_run_q;
	logic [1:0]             lcnt_q;
	logic                   out_valid_q;
	pix_t                   out_q [3];

	logic [2:0][XW-1:0]     x_q;
	coef_t                  lin_q [3][4];
	acc_t                   acc_q [3];

	logic                   pix_go, wr_go, shift;
	tpscm_cell_t            cell_d [NUM_CENTERS];
	tpscm_tag_t             tag_in, tag_s9, tag_s10, tag_s11;
	logic signed [CW-1:0]   phi_s9;

	logic signed [47:0]     a_s10 [3];
	logic signed [48:0]     b_s10 [3];
	logic signed [32:0]     c_s10 [3];
	logic [31:0]            d_s10 [3];
	acc_t                   t_s11 [3];
	logic signed [55:0]     lp_s1 [3];
	logic                   lin_v_s1;

	logic signed [63:0]     mhi [3];
	logic signed [63:0]     mlo [3];
	logic signed [63:0]     rsum [3];
	logic signed [63:0]     rsh [3];
	pix_t                   rsat [3];

	assign in_ready = (state_q == ST_IDLE);
	assign pix_go   = in_valid && in_ready && !action;
	assign wr_go    = in_valid && in_ready && action;
	assign shift    = (state_q == ST_RUN);

	// Ring of center cells. Cell k reads from cell k+1, so cell 0 is the head that
	// feeds the kernel; after NUM_CENTERS shifts every cell is back home.
	for (genvar k = 0; k < NUM_CENTERS; k++) begin : g_ring
		logic [2:0] wen;
		always_comb begin
			for (int j = 0; j < 3; j++) begin
				wen[j] = wr_go && (int'(coef_channel) == j) && (int'(coef_slot) == k);
			end
		end
		tpscm_cell #(.IDX(k)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.nxt    (cell_d[(k + 1) % NUM_CENTERS]),
			.wr_en  (wen),
			.wr_val (coef_value),
			.data   (cell_d[k])
		);
	end

	always_comb begin
		tag_in.vld  = shift;
		tag_in.last = (step_q == SW'(NUM_CENTERS - 1));
		tag_in.w    = cell_d[0].w;
	end

	tpscm_kernel #(.LN_TABLE_BITS(LN_TABLE_BITS)) u_kernel (
		.clk     (clk),
		.arst_n  (arst_n),
		.x       (x_q),
		.ctr     (cell_d[0].ctr),
		.tag_in  (tag_in),
		.phi     (phi_s9),
		.tag_out (tag_s9)
	);

	// Constant and linear coefficients live outside the ring; slot NUM_CENTERS is the
	// constant, the three slots after it the linear terms for L, a and b.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 3; c++) begin
				for (int s = 0; s < 4; s++) begin
					lin_q[c][s] <= '0;
				end
			end
		end else if (wr_go) begin
			for (int c = 0; c < 3; c++) begin
				for (int s = 0; s < 4; s++) begin
					if ((int'(coef_channel) == c) && (int'(coef_slot) == NUM_CENTERS + s)) begin
						lin_q[c][s] <= coef_value;
					end
				end
			end
		end
	end

	// Control: the ring runs NUM_CENTERS steps, the pipeline drains, and the result
	// moves to the output register once that register is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			lin_run_q   <= 1'b0;
			lcnt_q      <= '0;
			lin_v_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < 3; c++) begin
				out_q[c] <= '0;
			end
		end else begin
			lin_v_s1 <= lin_run_q;
			if (lin_run_q) begin
				lcnt_q <= lcnt_q + 2'd1;
				if (lcnt_q == 2'd2) begin
					lin_run_q <= 1'b0;
				end
			end
			// A new result may replace the one leaving in the same cycle.
			if ((state_q == ST_FIN) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pix_go) begin
						state_q   <= ST_RUN;
						step_q    <= '0;
						lin_run_q <= 1'b1;
						lcnt_q    <= '0;
					end
				end
				ST_RUN: begin
					step_q <= step_q + SW'(1);
					if (step_q == SW'(NUM_CENTERS - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (tag_s11.vld && tag_s11.last) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_q   <= rsat;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s10 <= '0;
			tag_s11 <= '0;
		end else begin
			tag_s10 <= tag_s9;
			tag_s11 <= tag_s10;
		end
	end

	// Center term: weight times phi as partial products with the weight split at
	// bit 20; the high product wraps at 64 bits before the clamp.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			mhi[c]  = ($signed(64'(a_s10[c])) <<< 20) + $signed(64'(b_s10[c]));
			mlo[c]  = ($signed(64'(c_s10[c])) <<< 20) + $signed({32'd0, d_s10[c]});
			rsum[c] = $signed(64'(acc_q[c])) + (64'sd1 <<< (COEF_FRAC_BITS - 7));
			rsh[c]  = rsum[c] >>> (COEF_FRAC_BITS - 6);
			if (rsh[c] > 64'sd32767) begin
				rsat[c] = 16'sh7fff;
			end else if (rsh[c] < -64'sd32768) begin
				rsat[c] = 16'sh8000;
			end else begin
				rsat[c] = XW'(rsh[c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			a_s10[c] <= $signed(tag_s9.w[c][CW-1:20]) * $signed(phi_s9[CW-1:12]);
			b_s10[c] <= $signed({1'b0, tag_s9.w[c][19:0]}) * $signed(phi_s9[CW-1:12]);
			c_s10[c] <= $signed(tag_s9.w[c][CW-1:20]) * $signed({1'b0, phi_s9[11:0]});
			d_s10[c] <= tag_s9.w[c][19:0] * phi_s9[11:0];
			t_s11[c] <= clamp_acc(mhi[c] + (mlo[c] >>> 12));
			lp_s1[c] <= $signed(lin_q[c][lcnt_q + 2'd1]) * $signed(x_q[lcnt_q]);
		end
		if (pix_go) begin
			x_q <= {in_blue_yellow, in_green_red, in_light};
		end
		for (int c = 0; c < 3; c++) begin
			if (pix_go) begin
				acc_q[c] <= ACC_W'(lin_q[c][0]);
			end else if (lin_v_s1) begin
				acc_q[c] <= clamp_acc($signed(64'(acc_q[c])) + $signed(64'(lp_s1[c] >>> 6)));
			end else if (tag_s11.vld) begin
				acc_q[c] <= clamp_acc($signed(64'(acc_q[c])) + $signed(64'(t_s11[c])));
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign out_light       = out_q[0];
	assign out_green_red   = out_q[1];
	assign out_blue_yellow = out_q[2];

	// Linear terms are added in the first cycles of a pixel and must never meet a
	// center term at the accumulator.
	`CHK_IMPL(a_lin_center_apart, lin_v_s1, !tag_s11.vld)
	// Center terms reach the accumulator only while a pixel is in flight.
	`CHK_IMPL(a_term_in_pixel, tag_s11.vld, (state_q == ST_RUN) || (state_q == ST_DRAIN))
	// The last ring step always hands over to the drain phase.
	`CHK_NEXT(a_run_ends, (state_q == ST_RUN) && (step_q == SW'(NUM_CENTERS - 1)), state_q == ST_DRAIN)

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the thin-plate spline color map.
// Depends on tpscm_pkg and the thin_plate_spline_color_map RTL.
`timescale 1ns / 100ps

module testbench;
	import tpscm_pkg::*;

	localparam int NCTR = NUM_CENTERS_DEF;
	localparam int NSLOT = NCTR + 4;
	localparam int SLOT_CONST = NCTR;
	localparam int SLOT_LIN_L = NCTR + 1;
	localparam int SLOT_LIN_B = NCTR + 3;
	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_COEF = 1'b1;
	localparam logic [1:0] CH_L = 2'd0;
	localparam logic [1:0] CH_A = 2'd1;
	localparam logic [1:0] CH_B = 2'd2;
	localparam logic [1:0] CH_BAD = 2'd3;
	localparam int MAX_GAP = 17;
	localparam int DRAIN_CYCLES = 80;

	typedef struct {
		pix_t l;
		pix_t a;
		pix_t b;
	} lab_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic action;
	pix_t in_light;
	pix_t in_green_red;
	pix_t in_blue_yellow;
	logic [1:0] coef_channel;
	logic [4:0] coef_slot;
	coef_t coef_value;
	logic out_valid;
	logic out_ready;
	pix_t out_light;
	pix_t out_green_red;
	pix_t out_blue_yellow;

	// Predictor state: the coefficient store and the log2 fraction table.
	longint spline_coefs [3][NSLOT];
	longint log2_tab [256];
	lab_t pending_pixels [$];
	int errors = 0;
	int hold_off_cycles = 0;

	thin_plate_spline_color_map uut (.*);

	// 4 ns clock.
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Fraction of log2(1 + idx/256), built by repeated squaring with truncation.
	function automatic longint log2_fraction(input int idx);
		longint unsigned x;
		longint r;
		x = (64'd1 << 30) + (64'(idx) << 22);
		r = 0;
		for (int i = 1; i <= LOG_FRAC; i++) begin
			x = (x * x) >> 30;
			if (x >= (64'd1 << 31)) begin
				r = r | (64'd1 << (LOG_FRAC - i));
				x = x >> 1;
			end
		end
		return r;
	endfunction

	// r^2 ln r in fixed point, 12 fraction bits; zero at zero distance.
	function automatic longint tps_kernel(input longint dsq);
		int e;
		longint frac;
		longint idx;
		longint lg;
		longint kk;
		if (dsq == 0) begin
			return 0;
		end
		e = 0;
		while (e < 63 && (dsq >> (e + 1)) != 0) begin
			e++;
		end
		frac = dsq - (64'sd1 << e);
		if (e >= 8) begin
			idx = frac >> (e - 8);
		end else begin
			idx = frac << (8 - e);
		end
		idx = idx & 255;
		lg = (longint'(e) << 24) + log2_tab[idx] - (64'sd12 << 24);
		kk = (lg * 363409) >>> 20;
		return (dsq * kk) >>> 24;
	endfunction

	function automatic logic signed [127:0] clamp60(input logic signed [127:0] v);
		if (v > (128'sd1 <<< 60)) begin
			return 128'sd1 <<< 60;
		end else if (v < -(128'sd1 <<< 60)) begin
			return -(128'sd1 <<< 60);
		end
		return v;
	endfunction

	// Maps one Lab pixel through the spline with the current coefficients.
	function automatic lab_t map_pixel(input pix_t pl, input pix_t pa, input pix_t pb);
		logic signed [127:0] acc [3];
		logic signed [127:0] c;
		longint x [3];
		longint dsq;
		longint df;
		longint phi;
		longint hi;
		longint lo;
		longint v [3];
		lab_t res;
		x[0] = pl;
		x[1] = pa;
		x[2] = pb;
		for (int ch = 0; ch < 3; ch++) begin
			acc[ch] = spline_coefs[ch][SLOT_CONST];
			for (int j = 0; j < 3; j++) begin
				c = spline_coefs[ch][SLOT_LIN_L + j];
				acc[ch] = clamp60(acc[ch] + ((c * x[j]) >>> 6));
			end
		end
		for (int k = 0; k < NCTR; k++) begin
			dsq = 0;
			for (int j = 0; j < 3; j++) begin
				df = x[j] - longint'(CENTER_TAB[(k % TABLE_CENTERS) * 3 + j]);
				dsq += df * df;
			end
			phi = tps_kernel(dsq);
			hi = phi >>> 12;
			lo = phi - hi * 4096;
			for (int ch = 0; ch < 3; ch++) begin
				c = spline_coefs[ch][k];
				acc[ch] = clamp60(acc[ch] + clamp60(c * hi + ((c * lo) >>> 12)));
			end
		end
		for (int ch = 0; ch < 3; ch++) begin
			c = (acc[ch] + (128'sd1 <<< 17)) >>> 18;
			if (c > 32767) begin
				c = 32767;
			end else if (c < -32768) begin
				c = -32768;
			end
			v[ch] = longint'(c);
		end
		res.l = pix_t'(v[0]);
		res.a = pix_t'(v[1]);
		res.b = pix_t'(v[2]);
		return res;
	endfunction

	// Sends one beat after a random gap and predicts its effect on acceptance.
	// The handshake is judged at the falling edge, where all signals are settled.
	task automatic offer_beat(input logic act, input pix_t pl, input pix_t pa, input pix_t pb,
			input logic [1:0] ch, input logic [4:0] slot, input coef_t val);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		in_light <= pl;
		in_green_red <= pa;
		in_blue_yellow <= pb;
		coef_channel <= ch;
		coef_slot <= slot;
		coef_value <= val;
		do @(negedge clk); while (!in_ready);
		if (act == ACT_PIXEL) begin
			pending_pixels.push_back(map_pixel(pl, pa, pb));
		end else if (ch != CH_BAD && slot < NSLOT) begin
			spline_coefs[ch][slot] = longint'(val);
		end
		@(posedge clk);
	endtask

	task automatic send_pixel(input pix_t pl, input pix_t pa, input pix_t pb);
		offer_beat(ACT_PIXEL, pl, pa, pb, coef_channel, coef_slot, coef_value);
	endtask

	task automatic write_coef(input logic [1:0] ch, input logic [4:0] slot, input coef_t val);
		offer_beat(ACT_COEF, in_light, in_green_red, in_blue_yellow, ch, slot, val);
	endtask

	task automatic idle_until_drained();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic coef_t random_coef();
		coef_t v;
		v = coef_t'({$urandom, $urandom});
		case ($urandom_range(0, 3))
			0: v = v >>> 30;
			1: v = v >>> 20;
			2: v = v >>> 12;
			default: ;
		endcase
		return v;
	endfunction

	function automatic pix_t random_channel(input int lo, input int hi);
		if ($urandom_range(0, 4) == 0) begin
			return pix_t'($urandom);
		end
		return pix_t'($urandom_range(0, hi - lo) + lo);
	endfunction

	// Receiver: random stall before each beat, plus a long hold when a test asks.
	initial begin
		int stall;
		lab_t want;
		out_ready = 1'b0;
		@(posedge clk);
		forever begin
			stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, MAX_GAP);
			if (hold_off_cycles > 0) begin
				stall = hold_off_cycles;
				hold_off_cycles = 0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(negedge clk); while (!out_valid);
			if (pending_pixels.size() == 0) begin
				$display("%0t: result beat with no pixel outstanding", $time);
				errors++;
			end else begin
				want = pending_pixels.pop_front();
				if (out_light !== want.l) begin
					$display("%0t: out_light expected %0d actual %0d", $time, want.l, out_light);
					errors++;
				end
				if (out_green_red !== want.a) begin
					$display("%0t: out_green_red expected %0d actual %0d", $time, want.a,
						out_green_red);
					errors++;
				end
				if (out_blue_yellow !== want.b) begin
					$display("%0t: out_blue_yellow expected %0d actual %0d", $time, want.b,
						out_blue_yellow);
					errors++;
				end
			end
			@(posedge clk);
		end
	end

	// Field extremes, zero distance, bad writes and saturation.
	task automatic test_directed();
		send_pixel(16'sd0, 16'sd0, 16'sd0);
		send_pixel(16'sh7fff, 16'sh7fff, 16'sh7fff);
		write_coef(CH_L, 5'(SLOT_CONST), coef_t'(40'sd1 <<< 30));
		write_coef(CH_L, 5'(SLOT_LIN_L), coef_t'(40'sd1 <<< 24));
		write_coef(CH_A, 5'(SLOT_LIN_L + 1), coef_t'(-(40'sd1 <<< 23)));
		write_coef(CH_B, 5'(SLOT_LIN_B), {1'b0, {39{1'b1}}});
		write_coef(CH_L, 5'd0, coef_t'(40'sd1 <<< 20));
		write_coef(CH_A, 5'(NCTR - 1), coef_t'(-(40'sd1 <<< 18)));
		write_coef(CH_B, 5'd5, {1'b1, {39{1'b0}}});
		// A pixel sitting exactly on a center gives that center zero kernel.
		send_pixel(16'sd2508, 16'sd881, 16'sd915);
		send_pixel(16'sh8000, 16'sh8000, 16'sh8000);
		send_pixel(16'sh7fff, 16'sh8000, 16'sh7fff);
		// Writes to the unused channel or past the last slot must be dropped.
		write_coef(CH_BAD, 5'd3, coef_t'(40'sd12345));
		write_coef(CH_L, 5'd28, coef_t'(40'sd99999));
		write_coef(CH_B, 5'd31, {40{1'b1}});
		send_pixel(16'sd1373, 16'sd4, -16'sd61);
		// Huge weights on centers 1 and 2 of L and center 7 of a drive the sums into the clamp and the outputs to the rails.
		write_coef(CH_L, 5'd1, {1'b0, {39{1'b1}}});
		write_coef(CH_L, 5'd2, {1'b1, {39{1'b0}}});
		write_coef(CH_A, 5'd7, {1'b0, {39{1'b1}}});
		send_pixel(16'sh7fff, 16'sh7fff, 16'sh8000);
		send_pixel(16'sh8000, 16'sh0001, 16'sh7ffe);
		send_pixel(16'sd4172, 16'sd1216, 16'sd1108);
		idle_until_drained();
	endtask

	// Random mix: mostly pixels in the Lab gamut, writes spread over all slots.
	task automatic test_random(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				write_coef(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)), random_coef());
			end else begin
				send_pixel(random_channel(-1000, 6800), random_channel(-4000, 4000),
					random_channel(-4000, 4000));
			end
		end
	endtask

	// Receiver holds off while pixels keep coming, so the block fills and stalls.
	task automatic test_backpressure();
		hold_off_cycles = 400;
		for (int i = 0; i < 12; i++) begin
			send_pixel(pix_t'($urandom), pix_t'($urandom), pix_t'($urandom));
		end
	endtask

	// Sender pauses until every result is back, then resumes.
	task automatic test_pause_and_resume();
		idle_until_drained();
		test_random(20);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_PIXEL;
		in_light = '0;
		in_green_red = '0;
		in_blue_yellow = '0;
		coef_channel = CH_L;
		coef_slot = '0;
		coef_value = '0;
		for (int i = 0; i < 256; i++) begin
			log2_tab[i] = log2_fraction(i);
		end
		for (int ch = 0; ch < 3; ch++) begin
			for (int s = 0; s < NSLOT; s++) begin
				spline_coefs[ch][s] = 0;
			end
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(500);
		test_backpressure();
		test_pause_and_resume();
		test_random(500);
		idle_until_drained();
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Worst case is about 1100 beats; the timeout allows them far more time than they need.
	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
